// File: hdl/pwd_pkg.sv
`default_nettype none
// ============================================================================
// pwd_pkg
// Shared types and constants of the priority work-group dispatcher.
// ============================================================================
package pwd_pkg;

    localparam int SLOT_W = 4;
    localparam int PRI_W  = 8;
    localparam int HALF_W = 16;
    localparam int WORD_W = 32;
    localparam int STAT_W = 2;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_LOADED     = 2'd0;
    localparam logic [STAT_W-1:0] ST_DISPATCHED = 2'd1;
    localparam logic [STAT_W-1:0] ST_RETIRED    = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY      = 2'd3;

    // One descriptor table entry
    typedef struct packed {
        logic [PRI_W-1:0]  pri;
        logic [HALF_W-1:0] gy;
        logic [HALF_W-1:0] gx;
        logic [HALF_W-1:0] sy;
        logic [HALF_W-1:0] sx;
        logic [HALF_W-1:0] py;
        logic [HALF_W-1:0] px;
        logic [WORD_W-1:0] tag;
    } entry_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;     // take the request payload, restart the scan
        logic load_write;  // write the captured descriptor, build a load result
        logic scan;        // read the table at the scan index and advance
        logic fetch;       // read the winning entry
        logic exec;        // step or retire the winning entry
        logic set_empty;   // build a no-valid-slot result
        logic publish;     // move the result to the output register
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic scan_last;
        logic found;
        logic out_free;
    } stat_t;

endpackage
`default_nettype wire

// File: hdl/pwd_ctrl.sv
`default_nettype none
// ============================================================================
// pwd_ctrl
// Sequencer of the dispatcher: accept, load or scan, fetch, execute, publish.
// ============================================================================
module pwd_ctrl
    import pwd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire logic  op,
    output cmd_t       cmd,
    input  wire stat_t stat
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOAD   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_FETCH  = 3'd4;
    localparam logic [2:0] S_EXEC   = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = op ? S_SCAN : S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.load_write = 1'b1;
                state_next     = S_FINISH;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                if (stat.found)
                begin
                    cmd.fetch  = 1'b1;
                    state_next = S_EXEC;
                end
                else
                begin
                    cmd.set_empty = 1'b1;
                    state_next    = S_FINISH;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_capture_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> state_reg != S_IDLE)
        else $error("accepted request did not start a sequence");

    a_exec_after_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EXEC |-> $past(state_reg) == S_FETCH)
        else $error("execute step entered without a fetch");

    a_publish_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> stat.out_free)
        else $error("result published while the output register is busy");

endmodule
`default_nettype wire

// File: hdl/pwd_datapath.sv
`default_nettype none
// ============================================================================
// pwd_datapath
// Descriptor table, priority scan, position step and result registers.
// ============================================================================
module pwd_datapath
    import pwd_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cmd_t              cmd,
    output stat_t                  stat,
    input  wire logic [SLOT_W-1:0] slot,
    input  wire logic [PRI_W-1:0]  priority_req,
    input  wire logic [HALF_W-1:0] groups_y,
    input  wire logic [HALF_W-1:0] groups_x,
    input  wire logic [HALF_W-1:0] size_y,
    input  wire logic [HALF_W-1:0] size_x,
    input  wire logic [WORD_W-1:0] program_tag,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [STAT_W-1:0]      status,
    output logic [SLOT_W-1:0]      chosen_slot,
    output logic [WORD_W-1:0]      origin_word,
    output logic [WORD_W-1:0]      length_word,
    output logic                   reload_needed,
    output logic [WORD_W-1:0]      reload_tag
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // Descriptor memory
    entry_t mem [TABLE_DEPTH];

    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [SLOT_W-1:0]      in_slot_reg;
    entry_t                 in_entry_reg;
    entry_t                 rd_data_reg;
    logic [IDX_W-1:0]       scan_idx_reg;
    logic [IDX_W-1:0]       rd_idx_reg;
    logic                   rd_pend_reg;
    logic [IDX_W-1:0]       best_idx_reg;
    logic [PRI_W-1:0]       best_pri_reg;
    logic                   best_found_reg;
    logic [WORD_W-1:0]      loaded_tag_reg;
    logic                   out_valid_reg;

    logic [STAT_W-1:0]      res_status_reg;
    logic [SLOT_W-1:0]      res_slot_reg;
    logic [WORD_W-1:0]      res_origin_reg;
    logic [WORD_W-1:0]      res_length_reg;
    logic                   res_reload_reg;
    logic [WORD_W-1:0]      res_tag_reg;

    logic [STAT_W-1:0]      out_status_reg;
    logic [SLOT_W-1:0]      out_slot_reg;
    logic [WORD_W-1:0]      out_origin_reg;
    logic [WORD_W-1:0]      out_length_reg;
    logic                   out_reload_reg;
    logic [WORD_W-1:0]      out_tag_reg;

    logic                   slot_ok;
    logic [IDX_W-1:0]       wr_slot_idx;
    logic                   retire;
    logic [HALF_W:0]        x_inc;
    logic                   x_wrap;
    entry_t                 stepped;
    logic [HALF_W-1:0]      prod_y;
    logic [HALF_W-1:0]      prod_x;
    logic                   tag_new;
    logic                   mem_we;
    logic [IDX_W-1:0]       mem_waddr;
    entry_t                 mem_wdata;
    logic [IDX_W-1:0]       rd_addr;

    assign slot_ok     = 32'(in_slot_reg) < 32'(TABLE_DEPTH);
    assign wr_slot_idx = IDX_W'(in_slot_reg);

    // Step and retire decision on the fetched entry
    assign retire = rd_data_reg.py >= rd_data_reg.gy;
    assign x_inc  = {1'b0, rd_data_reg.px} + 17'd1;
    assign x_wrap = x_inc >= {1'b0, rd_data_reg.gx};
    assign prod_y = rd_data_reg.py * rd_data_reg.sy;
    assign prod_x = rd_data_reg.px * rd_data_reg.sx;
    assign tag_new = rd_data_reg.tag != loaded_tag_reg;

    always_comb
    begin
        stepped = rd_data_reg;
        if (x_wrap)
        begin
            stepped.px = '0;
            stepped.py = rd_data_reg.py + 16'd1;
        end
        else
        begin
            stepped.px = x_inc[HALF_W-1:0];
        end
    end

    assign mem_we    = (cmd.load_write && slot_ok) || (cmd.exec && !retire);
    assign mem_waddr = cmd.exec ? best_idx_reg : wr_slot_idx;
    assign mem_wdata = cmd.exec ? stepped : in_entry_reg;
    assign rd_addr   = cmd.fetch ? best_idx_reg : scan_idx_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Request payload capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_slot_reg      <= slot;
            in_entry_reg.pri <= priority_req;
            in_entry_reg.gy  <= groups_y;
            in_entry_reg.gx  <= groups_x;
            in_entry_reg.sy  <= size_y;
            in_entry_reg.sx  <= size_x;
            in_entry_reg.py  <= '0;
            in_entry_reg.px  <= '0;
            in_entry_reg.tag <= program_tag;
        end
    end

    // Valid bits, scan bookkeeping and loaded program tag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            scan_idx_reg   <= '0;
            rd_idx_reg     <= '0;
            rd_pend_reg    <= 1'b0;
            best_idx_reg   <= '0;
            best_pri_reg   <= '0;
            best_found_reg <= 1'b0;
            loaded_tag_reg <= '0;
        end
        else
        begin
            if (cmd.load_write && slot_ok)
            begin
                valid_reg[wr_slot_idx] <= 1'b1;
            end
            else if (cmd.exec && retire)
            begin
                valid_reg[best_idx_reg] <= 1'b0;
            end

            rd_pend_reg <= cmd.scan;
            rd_idx_reg  <= scan_idx_reg;

            if (cmd.capture)
            begin
                scan_idx_reg   <= '0;
                best_found_reg <= 1'b0;
            end
            else
            begin
                if (cmd.scan)
                begin
                    scan_idx_reg <= scan_idx_reg + IDX_W'(1);
                end
                if (rd_pend_reg && valid_reg[rd_idx_reg] &&
                    (!best_found_reg || rd_data_reg.pri > best_pri_reg))
                begin
                    best_found_reg <= 1'b1;
                    best_idx_reg   <= rd_idx_reg;
                    best_pri_reg   <= rd_data_reg.pri;
                end
            end

            if (cmd.exec && !retire && tag_new)
            begin
                loaded_tag_reg <= rd_data_reg.tag;
            end
        end
    end

    // Result build
    always_ff @(posedge clk)
    begin
        if (cmd.load_write)
        begin
            res_status_reg <= ST_LOADED;
            res_slot_reg   <= in_slot_reg;
            res_origin_reg <= '0;
            res_length_reg <= '0;
            res_reload_reg <= 1'b0;
            res_tag_reg    <= '0;
        end
        else if (cmd.set_empty)
        begin
            res_status_reg <= ST_EMPTY;
            res_slot_reg   <= '0;
            res_origin_reg <= '0;
            res_length_reg <= '0;
            res_reload_reg <= 1'b0;
            res_tag_reg    <= '0;
        end
        else if (cmd.exec)
        begin
            res_slot_reg <= SLOT_W'(best_idx_reg);
            if (retire)
            begin
                res_status_reg <= ST_RETIRED;
                res_origin_reg <= '0;
                res_length_reg <= '0;
                res_reload_reg <= 1'b0;
                res_tag_reg    <= '0;
            end
            else
            begin
                res_status_reg <= ST_DISPATCHED;
                res_origin_reg <= {prod_y, prod_x};
                res_length_reg <= {rd_data_reg.sy, rd_data_reg.sx};
                res_reload_reg <= tag_new;
                res_tag_reg    <= tag_new ? rd_data_reg.tag : '0;
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.publish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg;
            out_origin_reg <= res_origin_reg;
            out_length_reg <= res_length_reg;
            out_reload_reg <= res_reload_reg;
            out_tag_reg    <= res_tag_reg;
        end
    end

    assign stat.scan_last = scan_idx_reg == IDX_W'(TABLE_DEPTH - 1);
    assign stat.found     = best_found_reg;
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign chosen_slot   = out_slot_reg;
    assign origin_word   = out_origin_reg;
    assign length_word   = out_length_reg;
    assign reload_needed = out_reload_reg;
    assign reload_tag    = out_tag_reg;

    a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> (!out_valid_reg || out_ready))
        else $error("result published over an untaken result");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_write && slot_ok |=> valid_reg[$past(wr_slot_idx)])
        else $error("loaded slot not marked valid");

    a_retire_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && retire |=> !valid_reg[$past(best_idx_reg)])
        else $error("retired slot still valid");

endmodule
`default_nettype wire

// File: hdl/priority_workgroup_dispatcher.sv
`default_nettype none
// ============================================================================
// priority_workgroup_dispatcher
// Kernel descriptor table with priority dispatch of work-group origins.
// ============================================================================
// A load request writes one descriptor slot and returns a "loaded" result.
// A dispatch request returns one result: the table sits in a memory with
// one write port and one read port, and the priority scan reads it one
// slot per cycle, then reads the winning entry once more to step its
// group position. One request is worked on at a time; the finished
// result waits in an output register, and the next request is accepted
// while it waits, though its own result is issued only after the previous
// one is taken. Loads to a slot at or beyond TABLE_DEPTH write nothing but
// still report "loaded" for that slot.
// ============================================================================
module priority_workgroup_dispatcher
    import pwd_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              op,
    input  wire logic [SLOT_W-1:0] slot,
    input  wire logic [PRI_W-1:0]  priority_req,
    input  wire logic [HALF_W-1:0] groups_y,
    input  wire logic [HALF_W-1:0] groups_x,
    input  wire logic [HALF_W-1:0] size_y,
    input  wire logic [HALF_W-1:0] size_x,
    input  wire logic [WORD_W-1:0] program_tag,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [STAT_W-1:0]      status,
    output logic [SLOT_W-1:0]      chosen_slot,
    output logic [WORD_W-1:0]      origin_word,
    output logic [WORD_W-1:0]      length_word,
    output logic                   reload_needed,
    output logic [WORD_W-1:0]      reload_tag
);

    cmd_t  cmd;
    stat_t stat;

    // Sequencer: decides load or scan, then walks fetch, execute, publish
    pwd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .op       (op),
        .cmd      (cmd),
        .stat     (stat)
    );

    // Table memory, scan tracker, group stepper and result registers
    pwd_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .slot          (slot),
        .priority_req  (priority_req),
        .groups_y      (groups_y),
        .groups_x      (groups_x),
        .size_y        (size_y),
        .size_x        (size_x),
        .program_tag   (program_tag),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .chosen_slot   (chosen_slot),
        .origin_word   (origin_word),
        .length_word   (length_word),
        .reload_needed (reload_needed),
        .reload_tag    (reload_tag)
    );

endmodule
`default_nettype wire

// File: bench/tb_priority_workgroup_dispatcher.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_priority_workgroup_dispatcher
// Self-checking bench for the priority work-group dispatcher: a short table
// of directed requests, then random descriptor jobs and noise, checked against
// typed-in results or a behavioral copy of the table, under random idling.
// ============================================================================
module tb_priority_workgroup_dispatcher
    import pwd_pkg::*;
();

    localparam int  TBL_DEPTH  = 16;
    localparam int  CLK_PERIOD = 12;
    localparam int  N_RANDOM   = 450;
    localparam int  DRAIN_CYC  = 40;   // idle time after the last result is seen

    localparam logic OP_LOAD     = 1'b0;
    localparam logic OP_DISPATCH = 1'b1;

    // One request as presented on the input channel
    typedef struct packed {
        logic              op;
        logic [SLOT_W-1:0] slot;
        logic [PRI_W-1:0]  pri;
        logic [HALF_W-1:0] gy;
        logic [HALF_W-1:0] gx;
        logic [HALF_W-1:0] sy;
        logic [HALF_W-1:0] sx;
        logic [WORD_W-1:0] tag;
    } req_t;

    // One result as seen on the output channel
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot;
        logic [WORD_W-1:0] origin;
        logic [WORD_W-1:0] length;
        logic              reload;
        logic [WORD_W-1:0] rtag;
    } res_t;

    // Stimulus row: request, plus a typed-in result when fixed is set
    typedef struct packed {
        req_t rq;
        logic fixed;
        res_t want;
    } row_t;

    // Directed part. Rows with fixed set carry a result that is obvious
    // (empty table, load acknowledge, zero-count retire); the rest are
    // left to the predictor.
    localparam int N_DIR = 22;
    localparam row_t DIRECTED [N_DIR] = '{
        // dispatch right after reset: no valid slot
        '{'{OP_DISPATCH, 4'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0},
          1'b1, '{ST_EMPTY, 4'd0, 32'd0, 32'd0, 1'b0, 32'd0}},
        // zero outer count, lowest priority
        '{'{OP_LOAD, 4'd0, 8'd0, 16'd0, 16'd1, 16'd0, 16'd0, 32'd0},
          1'b1, '{ST_LOADED, 4'd0, 32'd0, 32'd0, 1'b0, 32'd0}},
        // first dispatch of a zero outer count retires the slot
        '{'{OP_DISPATCH, 4'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0},
          1'b1, '{ST_RETIRED, 4'd0, 32'd0, 32'd0, 1'b0, 32'd0}},
        '{'{OP_DISPATCH, 4'd9, 8'hff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 32'hffffffff},
          1'b1, '{ST_EMPTY, 4'd0, 32'd0, 32'd0, 1'b0, 32'd0}},
        // top slot, top priority, all-ones sizes and tag
        '{'{OP_LOAD, 4'd15, 8'd255, 16'd2, 16'd2, 16'hffff, 16'hffff, 32'hffffffff},
          1'b1, '{ST_LOADED, 4'd15, 32'd0, 32'd0, 1'b0, 32'd0}},
        // same priority on a lower slot; zero inner count carries every step
        '{'{OP_LOAD, 4'd3, 8'd255, 16'd1, 16'd0, 16'd3, 16'd5, 32'h12345678},
          1'b1, '{ST_LOADED, 4'd3, 32'd0, 32'd0, 1'b0, 32'd0}},
        // tie: lower slot wins, reload flagged
        '{'{OP_DISPATCH, 4'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0}, 1'b0, '0},
        '{'{OP_DISPATCH, 4'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0}, 1'b0, '0},
        // walk the 2x2 grid of slot 15: x wraps into y, then the slot retires
        '{'{OP_DISPATCH, 4'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0}, 1'b0, '0},
        '{'{OP_DISPATCH, 4'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0}, 1'b0, '0},
        '{'{OP_DISPATCH, 4'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0}, 1'b0, '0},
        '{'{OP_DISPATCH, 4'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0}, 1'b0, '0},
        '{'{OP_DISPATCH, 4'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0}, 1'b0, '0},
        // full-range counts, tag equal to the one already loaded
        '{'{OP_LOAD, 4'd7, 8'd128, 16'hffff, 16'hffff, 16'h1234, 16'habcd, 32'hffffffff},
          1'b1, '{ST_LOADED, 4'd7, 32'd0, 32'd0, 1'b0, 32'd0}},
        '{'{OP_LOAD, 4'd8, 8'd127, 16'd3, 16'd1, 16'hffff, 16'd1, 32'd0},
          1'b1, '{ST_LOADED, 4'd8, 32'd0, 32'd0, 1'b0, 32'd0}},
        '{'{OP_DISPATCH, 4'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0}, 1'b0, '0},
        '{'{OP_DISPATCH, 4'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0}, 1'b0, '0},
        // reload an active slot at low priority: position restarts
        '{'{OP_LOAD, 4'd7, 8'd1, 16'd1, 16'd1, 16'd0, 16'd0, 32'd0},
          1'b1, '{ST_LOADED, 4'd7, 32'd0, 32'd0, 1'b0, 32'd0}},
        '{'{OP_DISPATCH, 4'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0}, 1'b0, '0},
        '{'{OP_DISPATCH, 4'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0}, 1'b0, '0},
        '{'{OP_LOAD, 4'd12, 8'd255, 16'd0, 16'hffff, 16'h5a5a, 16'ha5a5, 32'ha5a5a5a5},
          1'b1, '{ST_LOADED, 4'd12, 32'd0, 32'd0, 1'b0, 32'd0}},
        '{'{OP_DISPATCH, 4'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0}, 1'b0, '0}
    };

    // ------------------------------------------------------------------------
    // Clock, reset, block ports
    // ------------------------------------------------------------------------
    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              in_valid      = 1'b0;
    logic              in_ready;
    logic              op            = 1'b0;
    logic [SLOT_W-1:0] slot          = '0;
    logic [PRI_W-1:0]  priority_req  = '0;
    logic [HALF_W-1:0] groups_y      = '0;
    logic [HALF_W-1:0] groups_x      = '0;
    logic [HALF_W-1:0] size_y        = '0;
    logic [HALF_W-1:0] size_x        = '0;
    logic [WORD_W-1:0] program_tag   = '0;
    logic              out_valid;
    logic              out_ready     = 1'b0;
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] chosen_slot;
    logic [WORD_W-1:0] origin_word;
    logic [WORD_W-1:0] length_word;
    logic              reload_needed;
    logic [WORD_W-1:0] reload_tag;

    always #(CLK_PERIOD / 2) clk = ~clk;

    priority_workgroup_dispatcher #(
        .TABLE_DEPTH (TBL_DEPTH)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .slot          (slot),
        .priority_req  (priority_req),
        .groups_y      (groups_y),
        .groups_x      (groups_x),
        .size_y        (size_y),
        .size_x        (size_x),
        .program_tag   (program_tag),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .chosen_slot   (chosen_slot),
        .origin_word   (origin_word),
        .length_word   (length_word),
        .reload_needed (reload_needed),
        .reload_tag    (reload_tag)
    );

    // ------------------------------------------------------------------------
    // Descriptor table shadow: what the block should hold after each request
    // ------------------------------------------------------------------------
    logic              tbl_valid [TBL_DEPTH];
    logic [PRI_W-1:0]  tbl_pri   [TBL_DEPTH];
    logic [HALF_W-1:0] tbl_gy    [TBL_DEPTH];
    logic [HALF_W-1:0] tbl_gx    [TBL_DEPTH];
    logic [HALF_W-1:0] tbl_sy    [TBL_DEPTH];
    logic [HALF_W-1:0] tbl_sx    [TBL_DEPTH];
    logic [HALF_W-1:0] tbl_py    [TBL_DEPTH];
    logic [HALF_W-1:0] tbl_px    [TBL_DEPTH];
    logic [WORD_W-1:0] tbl_tag   [TBL_DEPTH];
    logic [WORD_W-1:0] cur_program;

    row_t stim [$];
    res_t pending_results [$];
    row_t cur_row;
    int   next_idx   = 0;
    int   accepted   = 0;
    int   mismatches = 0;
    int   burst_left = 0;
    int   gap_left   = 0;
    int   rx_cycle   = 0;
    logic [7:0] rx_pattern = 8'hff;

    // Apply one request to the shadow table and return the result it causes.
    function automatic res_t dispatcher_outcome(req_t r);
        res_t        o;
        int          win;
        int          k;
        logic [HALF_W-1:0] y;
        logic [HALF_W-1:0] x;
        logic [WORD_W-1:0] prod_y;
        logic [WORD_W-1:0] prod_x;
        o   = '0;
        win = -1;
        if (r.op == OP_LOAD)
        begin
            if (int'(r.slot) < TBL_DEPTH)
            begin
                tbl_valid[r.slot] = 1'b1;
                tbl_pri[r.slot]   = r.pri;
                tbl_gy[r.slot]    = r.gy;
                tbl_gx[r.slot]    = r.gx;
                tbl_sy[r.slot]    = r.sy;
                tbl_sx[r.slot]    = r.sx;
                tbl_py[r.slot]    = '0;
                tbl_px[r.slot]    = '0;
                tbl_tag[r.slot]   = r.tag;
            end
            o.status = ST_LOADED;
            o.slot   = r.slot;
            return o;
        end
        // highest priority wins; strict compare keeps the lowest slot on a tie
        for (k = 0; k < TBL_DEPTH; k++)
        begin
            if (tbl_valid[k] && (win < 0 || tbl_pri[k] > tbl_pri[win]))
                win = k;
        end
        if (win < 0)
        begin
            o.status = ST_EMPTY;
            return o;
        end
        o.slot = SLOT_W'(win);
        y = tbl_py[win];
        x = tbl_px[win];
        if (y >= tbl_gy[win])
        begin
            tbl_valid[win] = 1'b0;
            o.status       = ST_RETIRED;
            return o;
        end
        // step x, carry into y when x reaches the inner count
        if ({1'b0, x} + 17'd1 >= {1'b0, tbl_gx[win]})
        begin
            tbl_px[win] = '0;
            tbl_py[win] = y + 16'd1;
        end
        else
            tbl_px[win] = x + 16'd1;
        prod_y   = y * tbl_sy[win];
        prod_x   = x * tbl_sx[win];
        o.status = ST_DISPATCHED;
        o.origin = {prod_y[HALF_W-1:0], prod_x[HALF_W-1:0]};
        o.length = {tbl_sy[win], tbl_sx[win]};
        if (tbl_tag[win] != cur_program)
        begin
            cur_program = tbl_tag[win];
            o.reload    = 1'b1;
            o.rtag      = cur_program;
        end
        return o;
    endfunction

    // Random request. Narrow loads use small group counts, a few priority
    // levels (to force ties) and a small tag pool so jobs retire and reloads
    // both happen and not; wide ones sweep every field over its full range.
    function automatic req_t random_request(logic is_load, logic wide);
        req_t r;
        r.op   = is_load ? OP_LOAD : OP_DISPATCH;
        r.slot = SLOT_W'($urandom_range(0, TBL_DEPTH - 1));
        r.pri  = PRI_W'($urandom);
        r.gy   = HALF_W'($urandom);
        r.gx   = HALF_W'($urandom);
        r.sy   = HALF_W'($urandom);
        r.sx   = HALF_W'($urandom);
        r.tag  = $urandom;
        if (!wide)
        begin
            r.pri = PRI_W'($urandom_range(0, 3) * 85);
            r.gy  = HALF_W'($urandom_range(0, 3));
            r.gx  = HALF_W'($urandom_range(0, 3));
            r.tag = WORD_W'($urandom_range(0, 2));
        end
        return r;
    endfunction

    task automatic queue_request(req_t rq);
        row_t r;
        r       = '0;
        r.rq    = rq;
        r.fixed = 1'b0;
        stim.push_back(r);
    endtask

    // Compare one accepted result with the oldest expectation.
    task automatic check_result(res_t want);
        if (status !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, status);
            mismatches++;
        end
        if (chosen_slot !== want.slot)
        begin
            $error("chosen_slot: expected %0d, got %0d", want.slot, chosen_slot);
            mismatches++;
        end
        if (origin_word !== want.origin)
        begin
            $error("origin_word: expected %h, got %h", want.origin, origin_word);
            mismatches++;
        end
        if (length_word !== want.length)
        begin
            $error("length_word: expected %h, got %h", want.length, length_word);
            mismatches++;
        end
        if (reload_needed !== want.reload)
        begin
            $error("reload_needed: expected %0d, got %0d", want.reload, reload_needed);
            mismatches++;
        end
        if (reload_tag !== want.rtag)
        begin
            $error("reload_tag: expected %h, got %h", want.rtag, reload_tag);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Request side (bursts and gaps) and result side (stall pattern)
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            out_ready <= 1'b0;
        end
        else
        begin
            // predict at acceptance so the shadow table follows request order
            if (in_valid && in_ready)
            begin
                res_t got;
                got = dispatcher_outcome(cur_row.rq);
                pending_results.push_back(cur_row.fixed ? cur_row.want : got);
                accepted++;
            end

            // advance to the next request only when the channel is free
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (next_idx < stim.size())
                begin
                    cur_row = stim[next_idx];
                    next_idx++;
                    op           <= cur_row.rq.op;
                    slot         <= cur_row.rq.slot;
                    priority_req <= cur_row.rq.pri;
                    groups_y     <= cur_row.rq.gy;
                    groups_x     <= cur_row.rq.gx;
                    size_y       <= cur_row.rq.sy;
                    size_x       <= cur_row.rq.sx;
                    program_tag  <= cur_row.rq.tag;
                    in_valid     <= 1'b1;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        // a quarter of the bursts run back to back with no gap
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                    in_valid <= 1'b0;
            end

            // results
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result: status %0d, slot %0d", status, chosen_slot);
                    mismatches++;
                end
                else
                    check_result(pending_results.pop_front());
            end

            // out_ready follows a stall pattern picked at random from four kinds
            rx_cycle++;
            if (rx_cycle % 48 == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       rx_pattern = 8'hff;
                    1:       rx_pattern = 8'($urandom);
                    2:       rx_pattern = 8'h81;
                    default: rx_pattern = 8'hf0;
                endcase
            end
            out_ready <= rx_pattern[rx_cycle % 8];
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int n;
        for (n = 0; n < TBL_DEPTH; n++)
            tbl_valid[n] = 1'b0;
        cur_program = '0;

        for (n = 0; n < N_DIR; n++)
            stim.push_back(DIRECTED[n]);

        // Mostly jobs: load a few descriptors, then dispatch them toward
        // retirement. The rest is single noise requests over full ranges.
        while (stim.size() < N_DIR + N_RANDOM)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                repeat ($urandom_range(1, 3))
                    queue_request(random_request(1'b1, $urandom_range(0, 9) == 0));
                repeat ($urandom_range(1, 14))
                    queue_request(random_request(1'b0, 1'b1));
            end
            else
                queue_request(random_request(1'($urandom_range(0, 1)), 1'b1));
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // drain: every request taken, every result seen, then idle a while
        while (accepted < stim.size())
            @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog: a correct run needs well under a millisecond.
    initial
    begin
        #3ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: priority_workgroup_dispatcher.f
hdl/pwd_pkg.sv
hdl/pwd_ctrl.sv
hdl/pwd_datapath.sv
hdl/priority_workgroup_dispatcher.sv
bench/tb_priority_workgroup_dispatcher.sv
